/* rtl/frm_pkg.sv */
`default_nettype none

package frm_pkg;

	localparam int TS_W     = 32;
	localparam int FPS_W    = 24;
	localparam int FRAMES_W = 16;
	localparam int WPR_W    = 4;
	localparam int SUM_W    = 28;
	localparam int K_W      = 14;
	localparam int MUL_W    = FRAMES_W + K_W;
	localparam int FRAC_SH  = 14;
	localparam int NUM_W    = MUL_W + FRAC_SH;
	localparam int LEN_W    = 6;
	localparam int DATA_W   = 4 * FPS_W;

	// 10^6 * 256 = 15625 * 2^14
	localparam logic [K_W-1:0]      RATE_K        = 14'd15625;
	localparam logic [FPS_W-1:0]    FPS_FULL      = '1;
	localparam logic [LEN_W-1:0]    RATE_LEN      = 6'd44;
	localparam logic [LEN_W-1:0]    AVG_LEN       = 6'd28;
	localparam logic [TS_W-1:0]     WINDOW_US_RST = 32'd500000;
	localparam logic [WPR_W-1:0]    WPR_RST       = 4'd10;
	localparam logic [FRAMES_W-1:0] FRAMES_SAT    = '1;

	typedef enum logic {
		REG_WINDOW_US          = 1'b0,
		REG_WINDOWS_PER_REPORT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [TS_W-1:0]  den;
		logic [LEN_W-1:0] len;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             ovf;
		logic [FPS_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

/* rtl/frm_mul.sv */
`default_nettype none

module frm_mul
	import frm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [FRAMES_W-1:0] frames,
	output logic                     done,
	output logic [MUL_W-1:0]         prod
);

	logic [FRAMES_W-1:0] fr_q;
	logic [MUL_W-1:0]    acc_q;
	logic [4:0]          cnt_q;
	logic                busy_q;
	logic                done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(FRAMES_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// msb-first shift and add of the constant
	always_ff @(posedge clk) begin
		if (start) begin
			fr_q  <= frames;
			acc_q <= '0;
		end else if (busy_q) begin
			fr_q  <= {fr_q[FRAMES_W-2:0], 1'b0};
			acc_q <= {acc_q[MUL_W-2:0], 1'b0} + (fr_q[FRAMES_W-1] ? MUL_W'(RATE_K) : '0);
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

/* rtl/frm_div.sv */
`default_nettype none

module frm_div
	import frm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [NUM_W-1:0] num_q;
	logic [TS_W-1:0]  den_q;
	logic [TS_W-1:0]  rem_q;
	logic [FPS_W-1:0] quot_q;
	logic             ovf_q;
	logic [LEN_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [TS_W:0]   trial;
	logic [TS_W+1:0] diff;
	logic            ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = !diff[TS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - LEN_W'(1);
				if (cnt_q == LEN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.num;
			den_q  <= req.den;
			rem_q  <= '0;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= ge ? diff[TS_W-1:0] : trial[TS_W-1:0];
			quot_q <= {quot_q[FPS_W-2:0], ge};
			ovf_q  <= ovf_q | quot_q[FPS_W-1];
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

/* rtl/frm_stats.sv */
`default_nettype none

module frm_stats
	import frm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             update,
	input  wire logic             clear,
	input  wire logic [FPS_W-1:0] rate,
	input  wire logic [WPR_W-1:0] wpr,
	output logic                  report,
	output logic [WPR_W-1:0]      wd_new,
	output logic [SUM_W-1:0]      sum_new,
	output logic [FPS_W-1:0]      rate_max,
	output logic [FPS_W-1:0]      rate_min
);

	logic [WPR_W-1:0] wd_q;
	logic [SUM_W-1:0] sum_q;
	logic [FPS_W-1:0] max_q;
	logic [FPS_W-1:0] min_q;
	logic [WPR_W-1:0] need;

	assign wd_new  = wd_q + WPR_W'(1);
	assign sum_new = sum_q + SUM_W'(rate);
	assign need    = (wpr == '0) ? WPR_W'(1) : wpr;
	assign report  = (wd_new >= need) && (wd_new != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_q  <= '0;
			sum_q <= '0;
			max_q <= '0;
			min_q <= FPS_FULL;
		end else if (clear) begin
			wd_q  <= '0;
			sum_q <= '0;
			max_q <= '0;
			min_q <= FPS_FULL;
		end else if (update) begin
			wd_q  <= wd_new;
			sum_q <= sum_new;
			if (rate > max_q) begin
				max_q <= rate;
			end
			if (rate < min_q) begin
				min_q <= rate;
			end
		end
	end

	assign rate_max = max_q;
	assign rate_min = min_q;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (wd_q == '0 && sum_q == '0 && max_q == '0 && min_q == FPS_FULL))
		else $error("statistics not cleared");

	a_update_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(update && !clear) |=> (wd_q == $past(wd_new)))
		else $error("window count not advanced");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(update && clear))
		else $error("update and clear together");

endmodule

`default_nettype wire

/* rtl/frame_rate_monitor_unit.sv */
`default_nettype none

// Frame rate monitor. Each input transaction is one frame event carrying a
// 32-bit microsecond timestamp. Frames are counted in a window that opens at
// its first frame; when the wrapped elapsed time reaches window_us, one result
// transaction is produced with the window rate in unsigned Q16.8 frames per
// second (saturating), and every windows_per_report windows that result also
// carries the average, maximum and minimum rate (tuser high). Events that do
// not close a window leave the block idle. A closing event runs a bit-serial
// multiply and then a bit-serial divide; a report also computes the average
// on the same divider. The next event is accepted while a finished result
// waits at the output. Configuration writes must be made only while the
// block is idle; the block itself does not enforce this.
module frame_rate_monitor_unit
	import frm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [TS_W-1:0]   cfg_data,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [TS_W-1:0]   s_tdata,   // timestamp_us
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [DATA_W-1:0]      m_tdata,   // window_fps, avg_fps, max_fps, min_fps
	output logic                   m_tuser    // report_valid
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_STAT = 5'b01000,
		ST_AVG  = 5'b10000
	} state_t;

	state_t state_q;
	logic   out_pend_q;

	logic [TS_W-1:0]     window_us_q;
	logic [WPR_W-1:0]    wpr_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [TS_W-1:0]     start_q;
	logic [TS_W-1:0]     elapsed_q;
	logic [FPS_W-1:0]    rate_q;
	logic [FPS_W-1:0]    avg_q;
	logic                report_q;

	logic                m_tvalid_q;
	logic [DATA_W-1:0]   m_tdata_q;
	logic                m_tuser_q;

	logic                in_acc;
	logic [TS_W-1:0]     start_eff;
	logic [FRAMES_W-1:0] frames_inc;
	logic [TS_W-1:0]     elapsed;
	logic                closes;
	logic                out_load;

	logic                mul_start;
	logic                mul_done;
	logic [MUL_W-1:0]    mul_prod;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic                st_update;
	logic                st_clear;
	logic                st_report;
	logic [WPR_W-1:0]    st_wd_new;
	logic [SUM_W-1:0]    st_sum_new;
	logic [FPS_W-1:0]    st_max;
	logic [FPS_W-1:0]    st_min;

	assign s_tready   = (state_q == ST_IDLE) && !out_pend_q;
	assign in_acc     = s_tvalid && s_tready;
	assign start_eff  = (frames_q == '0) ? s_tdata : start_q;
	assign frames_inc = (frames_q == FRAMES_SAT) ? frames_q : frames_q + FRAMES_W'(1);
	assign elapsed    = s_tdata - start_eff;
	assign closes     = !(elapsed < window_us_q);
	assign mul_start  = in_acc && closes;
	assign out_load   = out_pend_q && (!m_tvalid_q || m_tready);
	assign st_update  = (state_q == ST_STAT);
	assign st_clear   = out_load && report_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_us_q <= WINDOW_US_RST;
			wpr_q       <= WPR_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_WINDOW_US:          window_us_q <= cfg_data;
				REG_WINDOWS_PER_REPORT: wpr_q       <= cfg_data[WPR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_pend_q <= 1'b0;
			frames_q   <= '0;
			start_q    <= '0;
			report_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_pend_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (closes) begin
							frames_q <= '0;
							start_q  <= s_tdata;
							state_q  <= ST_MUL;
						end else begin
							frames_q <= frames_inc;
							start_q  <= start_eff;
						end
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_STAT;
					end
				end
				ST_STAT: begin
					report_q <= st_report;
					if (st_report) begin
						state_q <= ST_AVG;
					end else begin
						out_pend_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_AVG: begin
					if (div_rsp.done) begin
						out_pend_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_start) begin
			elapsed_q <= elapsed;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			rate_q <= div_rsp.ovf ? FPS_FULL : div_rsp.quot;
		end
		if (state_q == ST_AVG && div_rsp.done) begin
			avg_q <= div_rsp.quot;
		end
	end

	always_comb begin
		div_req = '0;
		if (state_q == ST_STAT) begin
			div_req.start = st_report;
			div_req.num   = {st_sum_new, (NUM_W - SUM_W)'(0)};
			div_req.den   = TS_W'(st_wd_new);
			div_req.len   = AVG_LEN;
		end else begin
			div_req.start = (state_q == ST_MUL) && mul_done;
			div_req.num   = {mul_prod, FRAC_SH'(0)};
			div_req.den   = elapsed_q;
			div_req.len   = RATE_LEN;
		end
	end

	frm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.frames (frames_inc),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	frm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	frm_stats u_stats (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (st_update),
		.clear    (st_clear),
		.rate     (rate_q),
		.wpr      (wpr_q),
		.report   (st_report),
		.wd_new   (st_wd_new),
		.sum_new  (st_sum_new),
		.rate_max (st_max),
		.rate_min (st_min)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser_q <= report_q;
			if (report_q) begin
				m_tdata_q <= {st_min, st_max, avg_q, rate_q};
			end else begin
				m_tdata_q <= {(DATA_W - FPS_W)'(0), rate_q};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("loaded result not presented");

	a_no_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[DATA_W-1:FPS_W] == '0))
		else $error("statistics fields set without report");

	a_div_done_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV || state_q == ST_AVG))
		else $error("divider finished outside a divide state");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input taken while busy");

endmodule

`default_nettype wire
